// ===== rtl/core/bdq_pkg.sv =====
package bdq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMD_W  = 4;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 5;
   localparam int STAT_W = 2;
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 4'd0,
      CMD_PUSH_FRONT = 4'd1,
      CMD_POP_BACK   = 4'd2,
      CMD_POP_FRONT  = 4'd3,
      CMD_FIND_LEFT  = 4'd4,
      CMD_FIND_RIGHT = 4'd5,
      CMD_REMOVE_AT  = 4'd6,
      CMD_INSERT_AT  = 4'd7,
      CMD_CLEAR      = 4'd8
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_BADPOS = 2'd3
   } status_type;

   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] idx);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(idx);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return PTR_W'(sum);
   endfunction

endpackage

// ===== rtl/core/bdq_req_if.sv =====
interface bdq_req_if;
   import bdq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic signed [VAL_W-1:0]  item_value;
   logic [POS_W-1:0]         position;

   modport source (output valid, cmd, item_value, position, input ready);
   modport sink   (input valid, cmd, item_value, position, output ready);
endinterface

// ===== rtl/core/bdq_rsp_if.sv =====
interface bdq_rsp_if;
   import bdq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [VAL_W-1:0]  out_value;
   logic                     found;
   logic [POS_W-1:0]         found_index;
   logic [POS_W-1:0]         length;
   logic [STAT_W-1:0]        status;

   modport source (output valid, out_value, found, found_index, length, status,
                   input ready);
   modport sink   (input valid, out_value, found, found_index, length, status,
                   output ready);
endinterface

// ===== rtl/core/bounded_deque_with_search_core.sv =====
// Bounded double-ended queue of signed values with search, insert and remove.
// req_if (sink): one command beat carries cmd, item_value and position.
// rsp_if (source): exactly one result beat per command, in command order,
//   carrying out_value, found, found_index, length and status.
// Command flow: accept in S_IDLE, execute in S_EXEC, then finish in S_DONE.
//   push, clear, failed commands: complete in S_EXEC
//   pop: one registered read of the end slot in S_WALK
//   search: S_WALK reads elements until a match stops it or all are read
//     (no element is read on an empty queue)
//   remove/insert: S_WALK shifts the elements that move, none when none move
// A new command can be accepted in the same cycle the previous result is raised.
// One storage RAM with a registered read port serves every command that uses storage;
// walks read one slot per cycle and write the shifted slot in the following cycle.
// A new command is taken only when the sequencer is idle; the result sits in
// an output register, so the next command may be taken while it waits.
// If the receiver stalls with a result still held, the next finished result
// waits in the sequencer until the output register frees.
// Reset (synchronous) empties the queue, sets the head to slot 0 and drops
// any pending result; storage contents are not cleared.
module bounded_deque_with_search_core (
   input  logic             clock,
   input  logic             reset,
   bdq_req_if.sink          req_if,
   bdq_rsp_if.source        rsp_if
);
   import bdq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_WALK = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0]   key_ff, key_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        nxt_ff, nxt_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic                    up_ff, up_in;
   logic                    rv_ff, rv_in;
   logic [CNT_W-1:0]        ri_ff, ri_in;
   logic [DATA_WIDTH-1:0]   res_val_ff, res_val_in;
   logic                    res_found_ff, res_found_in;
   logic [CNT_W-1:0]        res_idx_ff, res_idx_in;
   status_type              res_stat_ff, res_stat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]        rsp_val_ff, rsp_val_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic [POS_W-1:0]        rsp_len_ff, rsp_len_in;
   status_type              rsp_stat_ff, rsp_stat_in;

   logic                    wr_en;
   logic [PTR_W-1:0]        wr_addr;
   logic [DATA_WIDTH-1:0]   wr_data;
   logic                    rd_en;
   logic [PTR_W-1:0]        rd_addr;
   logic [DATA_WIDTH-1:0]   rd_data;

   logic                    full;
   logic                    empty;
   logic                    stop;
   logic [PTR_W-1:0]        head_dec;
   logic [PTR_W-1:0]        head_inc;

   bdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_dec = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - PTR_W'(1);
   assign head_inc = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_value   = rsp_val_ff;
   assign rsp_if.found       = rsp_found_ff;
   assign rsp_if.found_index = rsp_idx_ff;
   assign rsp_if.length      = rsp_len_ff;
   assign rsp_if.status      = rsp_stat_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      nxt_in       = nxt_ff;
      left_in      = left_ff;
      up_in        = up_ff;
      rv_in        = rv_ff;
      ri_in        = ri_ff;
      res_val_in   = res_val_ff;
      res_found_in = res_found_ff;
      res_idx_in   = res_idx_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_val_in   = rsp_val_ff;
      rsp_found_in = rsp_found_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_stat_in  = rsp_stat_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = key_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      stop         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               cmd_in   = cmd_type'(req_if.cmd);
               key_in   = DATA_WIDTH'(req_if.item_value);
               pos_in   = req_if.position;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_val_in   = '0;
            res_found_in = 1'b0;
            res_idx_in   = '0;
            res_stat_in  = STAT_OK;
            rv_in        = 1'b0;
            left_in      = '0;
            state_in     = S_DONE;
            case (cmd_ff)
               CMD_PUSH_BACK: begin
                  if (full) begin
                     res_stat_in = STAT_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = slot_of(head_ff, count_ff);
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               CMD_PUSH_FRONT: begin
                  if (full) begin
                     res_stat_in = STAT_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = head_dec;
                     head_in  = head_dec;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               CMD_POP_BACK: begin
                  if (empty) begin
                     res_stat_in = STAT_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = slot_of(head_ff, count_ff - CNT_W'(1));
                     rv_in    = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_WALK;
                  end
               end
               CMD_POP_FRONT: begin
                  if (empty) begin
                     res_stat_in = STAT_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     rv_in    = 1'b1;
                     head_in  = head_inc;
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_WALK;
                  end
               end
               CMD_FIND_LEFT: begin
                  res_idx_in = count_ff;
                  nxt_in     = '0;
                  left_in    = count_ff;
                  up_in      = 1'b1;
                  state_in   = S_WALK;
               end
               CMD_FIND_RIGHT: begin
                  res_idx_in = count_ff;
                  nxt_in     = count_ff - CNT_W'(1);
                  left_in    = count_ff;
                  up_in      = 1'b0;
                  state_in   = S_WALK;
               end
               CMD_REMOVE_AT: begin
                  if (CMP_W'(pos_ff) >= CMP_W'(count_ff)) begin
                     res_stat_in = STAT_BADPOS;
                  end else begin
                     nxt_in   = CNT_W'(pos_ff) + CNT_W'(1);
                     left_in  = count_ff - CNT_W'(1) - CNT_W'(pos_ff);
                     up_in    = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_WALK;
                  end
               end
               CMD_INSERT_AT: begin
                  if (CMP_W'(pos_ff) > CMP_W'(count_ff)) begin
                     res_stat_in = STAT_BADPOS;
                  end else if (full) begin
                     res_stat_in = STAT_FULL;
                  end else begin
                     nxt_in   = count_ff - CNT_W'(1);
                     left_in  = count_ff - CNT_W'(pos_ff);
                     up_in    = 1'b0;
                     count_in = count_ff + CNT_W'(1);
                     state_in = S_WALK;
                  end
               end
               CMD_CLEAR: begin
                  count_in = '0;
                  head_in  = '0;
               end
               default: begin
               end
            endcase
         end

         S_WALK: begin
            rv_in = 1'b0;
            if (rv_ff) begin
               case (cmd_ff)
                  CMD_POP_BACK, CMD_POP_FRONT: begin
                     res_val_in = rd_data;
                  end
                  CMD_FIND_LEFT, CMD_FIND_RIGHT: begin
                     if (rd_data == key_ff) begin
                        res_found_in = 1'b1;
                        res_idx_in   = ri_ff;
                        stop         = 1'b1;
                     end
                  end
                  CMD_REMOVE_AT: begin
                     wr_en   = 1'b1;
                     wr_addr = slot_of(head_ff, ri_ff - CNT_W'(1));
                     wr_data = rd_data;
                  end
                  CMD_INSERT_AT: begin
                     wr_en   = 1'b1;
                     wr_addr = slot_of(head_ff, ri_ff + CNT_W'(1));
                     wr_data = rd_data;
                  end
                  default: begin
                  end
               endcase
            end
            if (stop) begin
               state_in = S_DONE;
            end else if (left_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = slot_of(head_ff, nxt_ff);
               rv_in   = 1'b1;
               ri_in   = nxt_ff;
               nxt_in  = up_ff ? nxt_ff + CNT_W'(1) : nxt_ff - CNT_W'(1);
               left_in = left_ff - CNT_W'(1);
            end else if (!rv_ff) begin
               if (cmd_ff == CMD_INSERT_AT) begin
                  wr_en   = 1'b1;
                  wr_addr = slot_of(head_ff, CNT_W'(pos_ff));
                  wr_data = key_ff;
               end
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = VAL_W'(res_val_ff);
               rsp_found_in = res_found_ff;
               rsp_idx_in   = POS_W'(res_idx_ff);
               rsp_len_in   = POS_W'(count_ff);
               rsp_stat_in  = res_stat_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      pos_ff       <= pos_in;
      nxt_ff       <= nxt_in;
      left_ff      <= left_in;
      up_ff        <= up_in;
      ri_ff        <= ri_in;
      res_val_ff   <= res_val_in;
      res_found_ff <= res_found_in;
      res_idx_ff   <= res_idx_in;
      res_stat_ff  <= res_stat_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_found_ff <= rsp_found_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count above depth");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> state_ff == S_EXEC)
      else $error("accepted command not executed");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside completion");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE || state_ff == S_DONE |-> !wr_en)
      else $error("storage write while no command active");

endmodule

// ===== rtl/core/bdq_ram.sv =====
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
